[rtl/glyph_quad_layout_macros.svh]
// Assertion helpers for the RTL files; glq_ctrl.sv includes them.
`ifndef GLYPH_QUAD_LAYOUT_MACROS_SVH
`define GLYPH_QUAD_LAYOUT_MACROS_SVH

// Same-cycle implication, sampled on i_clk, off during reset.
`define GLQ_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on i_clk, off during reset.
`define GLQ_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/glq_pkg.sv]
`timescale 1ns / 1ps
package glq_pkg;

    localparam int COORD_W = 24;
    localparam int TEX_W   = 17;
    localparam int VB_W    = 14;
    localparam int DIM_W   = 23;
    localparam int SAT_W   = 48;
    localparam int DEN_W   = 15;

    localparam logic [6:0]  NEWLINE_CODE = 7'd10;
    localparam int          ADV_SHIFT    = 6;
    localparam logic [16:0] TEX_ONE      = 17'd65536;
    localparam logic signed [SAT_W-1:0] COORD_MAX = SAT_W'(8388607);
    localparam logic signed [SAT_W-1:0] COORD_MIN = -SAT_W'(8388608);

    // configuration register indexes
    localparam logic [1:0] CFG_SIZE_PX   = 2'd0;
    localparam logic [1:0] CFG_FONT_BASE = 2'd1;
    localparam logic [1:0] CFG_ATLAS_DIM = 2'd2;

    // divide operations, in the order they run for one character
    localparam logic [3:0] OP_BX   = 4'd0;
    localparam logic [3:0] OP_HBY  = 4'd1;
    localparam logic [3:0] OP_W    = 4'd2;
    localparam logic [3:0] OP_H    = 4'd3;
    localparam logic [3:0] OP_ADV  = 4'd4;
    localparam logic [3:0] OP_AX   = 4'd5;
    localparam logic [3:0] OP_AY   = 4'd6;
    localparam logic [3:0] OP_AXW  = 4'd7;
    localparam logic [3:0] OP_AYH  = 4'd8;

    localparam logic [1:0] CORNER_TL = 2'd0;
    localparam logic [1:0] CORNER_BL = 2'd1;
    localparam logic [1:0] CORNER_BR = 2'd2;
    localparam logic [1:0] CORNER_TR = 2'd3;

    typedef struct packed {
        logic                action;
        logic [6:0]          char_code;
        logic                last_char;
        logic [7:0]          glyph_w;
        logic [7:0]          glyph_h;
        logic signed [7:0]   bear_x;
        logic signed [7:0]   bear_y;
        logic [11:0]         atlas_px_x;
        logic [11:0]         atlas_px_y;
        logic [15:0]         advance_26_6;
    } t_in_item;

    typedef struct packed {
        logic signed [COORD_W-1:0] vert_x;
        logic signed [COORD_W-1:0] vert_y;
        logic [TEX_W-1:0]          tex_u;
        logic [TEX_W-1:0]          tex_v;
        logic [1:0]                corner;
        logic [VB_W-1:0]           vertex_base;
        logic                      gap;
        logic                      last;
        logic [DIM_W-1:0]          text_width;
        logic [DIM_W-1:0]          text_height;
    } t_out_item;

    typedef struct packed {
        logic [7:0]        w;
        logic [7:0]        h;
        logic signed [7:0] bx;
        logic signed [7:0] by;
        logic [11:0]       ax;
        logic [11:0]       ay;
        logic [15:0]       adv;
    } t_glyph;

    typedef struct packed {
        logic       accept;
        logic       start_str;
        logic       div_go;
        logic       div_store;
        logic [3:0] div_op;
        logic       calc;
        logic       nl_upd;
        logic       emit;
        logic [1:0] emit_corner;
        logic       finish;
    } t_cmd;

    typedef struct packed {
        logic in_load;
        logic newline;
        logic started;
        logic div_done;
        logic out_free;
    } t_stat;

    function automatic logic signed [COORD_W-1:0] sat_coord(
        input logic signed [SAT_W-1:0] v);
        logic signed [SAT_W-1:0] r;
        r = v;
        if (v > COORD_MAX) r = COORD_MAX;
        if (v < COORD_MIN) r = COORD_MIN;
        return r[COORD_W-1:0];
    endfunction

    function automatic logic [DIM_W-1:0] clamp_dim(input logic signed [SAT_W-1:0] v);
        logic signed [SAT_W-1:0] r;
        r = v;
        if (v > COORD_MAX) r = COORD_MAX;
        if (v < SAT_W'(0)) r = SAT_W'(0);
        return r[DIM_W-1:0];
    endfunction

endpackage

[rtl/glq_div.sv]
`timescale 1ns / 1ps
module glq_div
    import glq_pkg::*;
#(
    parameter int DW = 30
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [DW-1:0]    i_num,
    input  logic [DEN_W-1:0] i_den,
    output logic             o_done,
    output logic [DW-1:0]    o_quot,
    output logic             o_rem_nz
);

    localparam int CNT_W = $clog2(DW + 1);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [DEN_W-1:0] r_rem;
    logic [DEN_W-1:0] r_den;
    logic [DW-1:0]    r_quot;

    logic [DEN_W:0]   shifted;
    logic [DEN_W+1:0] diff;

    always_comb begin
        shifted = {r_rem, r_quot[DW-1]};
        diff    = {1'b0, shifted} - {2'b00, r_den};
    end

    // restoring division, one quotient bit per cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(DW);
                r_rem  <= '0;
                r_den  <= i_den;
                r_quot <= i_num;
            end else if (r_busy) begin
                if (!diff[DEN_W+1]) begin
                    r_rem  <= diff[DEN_W-1:0];
                    r_quot <= {r_quot[DW-2:0], 1'b1};
                end else begin
                    r_rem  <= shifted[DEN_W-1:0];
                    r_quot <= {r_quot[DW-2:0], 1'b0};
                end
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done   = r_done;
    assign o_quot   = r_quot;
    assign o_rem_nz = (r_rem != '0);

endmodule

[rtl/glq_dp.sv]
`timescale 1ns / 1ps
module glq_dp
    import glq_pkg::*;
#(
    parameter int GLYPH_COUNT     = 128,
    parameter int MAX_TEXT_LEN    = 4096,
    parameter int COORD_FRAC_BITS = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [12:0] i_cfg_data,
    input  t_in_item    i_in_data,
    input  t_cmd        i_cmd,
    output t_stat       o_stat,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output t_out_item   o_out_data
);

    localparam int AW = $clog2(GLYPH_COUNT);
    localparam int CW = $clog2(MAX_TEXT_LEN);
    localparam int DW = (19 + COORD_FRAC_BITS > 30) ? 19 + COORD_FRAC_BITS : 30;
    localparam int SW = 20 + COORD_FRAC_BITS;
    localparam int XW = SW + 2;

    // configuration
    logic [7:0]  r_size;
    logic [7:0]  r_base;
    logic [12:0] r_dim;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size <= 8'd16;
            r_base <= 8'd48;
            r_dim  <= 13'd1024;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_SIZE_PX:   r_size <= i_cfg_data[7:0];
                CFG_FONT_BASE: r_base <= i_cfg_data[7:0];
                CFG_ATLAS_DIM: r_dim  <= i_cfg_data;
                default: ;
            endcase
        end
    end
    assign o_cfg_ready = 1'b1;

    // glyph table
    t_glyph   mem [GLYPH_COUNT];
    t_glyph   r_rd;
    t_in_item r_item;
    logic     r_oob;
    logic [7:0]  code_ext;
    logic [AW-1:0] addr;
    logic        in_range;

    assign code_ext = {1'b0, i_in_data.char_code};
    assign addr     = code_ext[AW-1:0];
    assign in_range = ({2'b00, i_in_data.char_code} < 9'(GLYPH_COUNT));

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_item <= i_in_data;
            r_oob  <= !in_range;
            r_rd   <= mem[addr];
            if (!i_in_data.action && in_range) begin
                mem[addr] <= '{w: i_in_data.glyph_w, h: i_in_data.glyph_h,
                               bx: i_in_data.bear_x, by: i_in_data.bear_y,
                               ax: i_in_data.atlas_px_x, ay: i_in_data.atlas_px_y,
                               adv: i_in_data.advance_26_6};
            end
        end
    end

    t_glyph g;
    assign g = r_oob ? '0 : r_rd;

    // divide operand selection
    logic [7:0]               base_eff;
    logic [12:0]              dim_eff;
    logic signed [10:0]       px;
    logic [12:0]              tpix;
    logic signed [19:0]       prod;
    logic signed [DW:0]       sn;
    logic [DW-1:0]            tn;
    logic                     is_tex;
    logic [DW-1:0]            div_num;
    logic [DEN_W-1:0]         div_den;
    logic                     div_done;
    logic [DW-1:0]            div_quot;
    logic                     div_rem_nz;

    always_comb begin
        base_eff = (r_base == 8'd0) ? 8'd1 : r_base;
        dim_eff  = (r_dim == 13'd0) ? 13'd1 : r_dim;
        is_tex   = i_cmd.div_op inside {[OP_AX:OP_AYH]};
        case (i_cmd.div_op)
            OP_BX:   px = 11'(g.bx);
            OP_HBY:  px = $signed({3'b000, g.h}) - 11'(g.by);
            OP_W:    px = $signed({3'b000, g.w});
            OP_H:    px = $signed({3'b000, g.h});
            OP_ADV:  px = $signed({1'b0, g.adv[15:ADV_SHIFT]});
            default: px = '0;
        endcase
        case (i_cmd.div_op)
            OP_AX:   tpix = {1'b0, g.ax};
            OP_AY:   tpix = {1'b0, g.ay};
            OP_AXW:  tpix = 13'(g.ax) + 13'(g.w);
            OP_AYH:  tpix = 13'(g.ay) + 13'(g.h);
            default: tpix = '0;
        endcase
        prod = px * $signed({1'b0, r_size});
        sn   = ((DW + 1)'(prod) <<< (COORD_FRAC_BITS + 1)) + (DW + 1)'(base_eff);
        tn   = (DW'(tpix) << 17) + DW'(dim_eff);
        if (is_tex) begin
            div_num = tn;
            div_den = DEN_W'({dim_eff, 1'b0});
        end else begin
            div_num = sn[DW] ? DW'(-sn) : sn[DW-1:0];
            div_den = DEN_W'({base_eff, 1'b0});
        end
    end

    glq_div #(.DW(DW)) u_div (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (i_cmd.div_go),
        .i_num    (div_num),
        .i_den    (div_den),
        .o_done   (div_done),
        .o_quot   (div_quot),
        .o_rem_nz (div_rem_nz)
    );

    // layout state
    logic signed [COORD_W-1:0] r_pen_x, r_pen_y, r_maxw, r_acc;
    logic [CW-1:0]             r_count;
    logic                      r_started;
    logic                      r_neg;
    logic signed [SW-1:0]      r_sc [5];
    logic [TEX_W-1:0]          r_tx [4];
    logic signed [XW-1:0]      r_xp, r_yp;
    logic signed [SAT_W-1:0]   step;
    logic signed [DW:0]        sq;
    logic [CW:0]               count_inc;
    logic [3:0]                tx_idx;

    assign step      = SAT_W'(r_size) <<< COORD_FRAC_BITS;
    assign sq        = r_neg ? -$signed({1'b0, div_quot}) - (DW + 1)'(div_rem_nz)
                             : $signed({1'b0, div_quot});
    assign count_inc = {1'b0, r_count} + 1'b1;
    assign tx_idx    = i_cmd.div_op - OP_AX;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pen_x   <= '0;
            r_pen_y   <= sat_coord(SAT_W'(16) <<< COORD_FRAC_BITS);
            r_maxw    <= '0;
            r_acc     <= '0;
            r_count   <= '0;
            r_started <= 1'b0;
        end else begin
            if (i_cmd.start_str) begin
                r_pen_x   <= '0;
                r_pen_y   <= sat_coord(step);
                r_maxw    <= '0;
                r_acc     <= '0;
                r_count   <= '0;
                r_started <= 1'b1;
            end
            if (i_cmd.nl_upd) begin
                if (r_pen_x > r_maxw) r_maxw <= r_pen_x;
                r_pen_x <= '0;
                r_pen_y <= sat_coord(SAT_W'(r_pen_y) + step);
                r_acc   <= sat_coord(SAT_W'(r_acc) + step);
            end
            if (i_cmd.calc) begin
                r_pen_x <= sat_coord(SAT_W'(r_pen_x) + SAT_W'(r_sc[4]));
            end
            if (i_cmd.finish) begin
                r_count <= (count_inc >= (CW + 1)'(MAX_TEXT_LEN)) ? '0 : count_inc[CW-1:0];
                if (r_item.last_char) begin
                    // end of string: back to the start-of-line position
                    r_pen_x   <= '0;
                    r_pen_y   <= sat_coord(step);
                    r_maxw    <= '0;
                    r_acc     <= '0;
                    r_count   <= '0;
                    r_started <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.div_go) begin
            r_neg <= !is_tex && sn[DW];
        end
        if (i_cmd.div_store) begin
            if (is_tex) begin
                r_tx[tx_idx[1:0]] <= (div_quot > DW'(TEX_ONE)) ? TEX_ONE : div_quot[TEX_W-1:0];
            end else begin
                r_sc[i_cmd.div_op[2:0]] <= SW'(sq);
            end
        end
        if (i_cmd.calc) begin
            r_xp <= XW'(r_pen_x) + XW'(r_sc[0]);
            r_yp <= XW'(r_pen_y) + XW'(r_sc[1]);
        end
    end

    // result assembly and output register
    logic                    right, top;
    logic signed [SAT_W-1:0] x_w, y_w, wmax;
    t_out_item               res;
    logic                    r_out_valid;
    t_out_item               r_out;
    logic                    nl;

    assign nl = (r_item.char_code == NEWLINE_CODE);

    always_comb begin
        right = (i_cmd.emit_corner == CORNER_BR) || (i_cmd.emit_corner == CORNER_TR);
        top   = (i_cmd.emit_corner == CORNER_TL) || (i_cmd.emit_corner == CORNER_TR);
        x_w   = SAT_W'(r_xp) + (right ? SAT_W'(r_sc[2]) : SAT_W'(0));
        y_w   = SAT_W'(r_yp) - (top ? SAT_W'(r_sc[3]) : SAT_W'(0));
        wmax  = (r_pen_x > r_maxw) ? SAT_W'(r_pen_x) : SAT_W'(r_maxw);
        res             = '0;
        if (nl) begin
            res.gap  = 1'b1;
            res.last = 1'b1;
        end else begin
            res.vert_x      = sat_coord(x_w);
            res.vert_y      = sat_coord(y_w);
            res.tex_u       = right ? r_tx[2] : r_tx[0];
            res.tex_v       = top ? r_tx[1] : r_tx[3];
            res.corner      = i_cmd.emit_corner;
            res.vertex_base = VB_W'({r_count, 2'b00});
            res.last        = (i_cmd.emit_corner == CORNER_TR);
        end
        if (r_item.last_char) begin
            res.text_width  = clamp_dim(wmax);
            res.text_height = clamp_dim(SAT_W'(r_acc) + step);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) r_out <= res;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    assign o_stat.in_load  = !i_in_data.action;
    assign o_stat.newline  = nl;
    assign o_stat.started  = r_started;
    assign o_stat.div_done = div_done;
    assign o_stat.out_free = !r_out_valid || i_out_ready;

endmodule

[rtl/glq_ctrl.sv]
`timescale 1ns / 1ps
`include "glyph_quad_layout_macros.svh"
module glq_ctrl
    import glq_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    output logic  o_in_ready,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_DIV_GO,
        S_DIV_WAIT,
        S_CALC,
        S_NL,
        S_EMIT
    } t_state;

    t_state     r_state, n_state;
    logic [3:0] r_op, n_op;
    logic [1:0] r_corner, n_corner;
    logic       final_emit;

    assign final_emit = i_stat.newline || (r_corner == CORNER_TR);

    always_comb begin
        n_state          = r_state;
        n_op             = r_op;
        n_corner         = r_corner;
        o_in_ready       = 1'b0;
        o_cmd            = '0;
        o_cmd.div_op     = r_op;
        o_cmd.emit_corner = r_corner;
        case (r_state)
            S_IDLE: begin
                o_in_ready   = 1'b1;
                o_cmd.accept = i_in_valid;
                // loads finish at the accept edge
                if (i_in_valid && !i_stat.in_load) n_state = S_READ;
            end
            S_READ: begin
                o_cmd.start_str = !i_stat.started;
                n_op            = OP_BX;
                n_corner        = CORNER_TL;
                n_state         = i_stat.newline ? S_NL : S_DIV_GO;
            end
            S_DIV_GO: begin
                o_cmd.div_go = 1'b1;
                n_state      = S_DIV_WAIT;
            end
            S_DIV_WAIT: begin
                if (i_stat.div_done) begin
                    o_cmd.div_store = 1'b1;
                    if (r_op == OP_AYH) begin
                        n_state = S_CALC;
                    end else begin
                        n_op    = r_op + 1'b1;
                        n_state = S_DIV_GO;
                    end
                end
            end
            S_CALC: begin
                o_cmd.calc = 1'b1;
                n_state    = S_EMIT;
            end
            S_NL: begin
                o_cmd.nl_upd = 1'b1;
                n_state      = S_EMIT;
            end
            S_EMIT: begin
                if (i_stat.out_free) begin
                    o_cmd.emit = 1'b1;
                    if (final_emit) begin
                        o_cmd.finish = 1'b1;
                        n_state      = S_IDLE;
                    end else begin
                        n_corner = r_corner + 1'b1;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_op     <= '0;
            r_corner <= '0;
        end else begin
            r_state  <= n_state;
            r_op     <= n_op;
            r_corner <= n_corner;
        end
    end

    `GLQ_ASSERT_NOW(a_emit_free, o_cmd.emit, i_stat.out_free, "result overwrites pending output")
    `GLQ_ASSERT_NOW(a_div_waited, i_stat.div_done, r_state == S_DIV_WAIT, "divide done unexpected")
    `GLQ_ASSERT_NEXT(a_place_read, o_cmd.accept && !i_stat.in_load, r_state == S_READ,
                     "place item did not start")

endmodule

[rtl/glyph_quad_layout.sv]
`timescale 1ns / 1ps
// Text layout engine: turns a string of characters into textured quad vertices.
// Input channel (i_in_valid/o_in_ready, i_in_data): a load transaction writes
// one glyph metrics entry. A place transaction emits four corner vertices, or
// one gap result for a newline.
// Output channel (o_out_valid/i_out_ready, o_out_data): one vertex per
// transaction; last marks the final result of a character, and the result of
// the string's final character carries text_width and text_height.
// Config channel (i_cfg_valid/o_cfg_ready): always ready, one register per write.
// A character runs nine divisions on one shared restoring divider, one quotient
// bit a cycle (DW = 30 at the default fraction width), then emits its four
// corner results; a newline skips the divisions.
// The next transaction is taken while the last result waits in the output register.
// Reset: registers return to size 16, base 48, atlas 1024 and the pen goes to
// the start of the first line; the glyph table holds no data until loaded.
// A stalled receiver holds the block in its output state; nothing is dropped.
module glyph_quad_layout
    import glq_pkg::*;
#(
    parameter int GLYPH_COUNT     = 128,
    parameter int MAX_TEXT_LEN    = 4096,
    parameter int COORD_FRAC_BITS = 8
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_item  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out_data,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [12:0] i_cfg_data
);

    t_cmd  cmd;
    t_stat stat;

    glq_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    glq_dp #(
        .GLYPH_COUNT     (GLYPH_COUNT),
        .MAX_TEXT_LEN    (MAX_TEXT_LEN),
        .COORD_FRAC_BITS (COORD_FRAC_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_data   (i_in_data),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule
